// ----- hw/rtl/gfr_pkg.sv -----
// ----------------------------------------------------------------------------
// gfr_pkg
// Shared types and constants of the family record parser.
// ----------------------------------------------------------------------------
package gfr_pkg;

    localparam int MAX_OPS_DEF     = 128;
    localparam int MAX_CATALOG_DEF = 96;
    localparam int NAME_BYTES_DEF  = 16;

    localparam logic [15:0] CTRL_TYPE_RST = 16'd16;
    localparam logic [15:0] HDR_BYTES     = 16'd20;
    localparam logic [15:0] POS_MAX       = 16'hffff;
    localparam logic [7:0]  LOW_BYTE      = 8'hff;
    localparam int          OFS_W         = 18;
    localparam int          SLOT_W        = 7;

    localparam logic [13:0] A_FAMILY_ID   = 14'd1;
    localparam logic [13:0] A_FAMILY_NAME = 14'd2;
    localparam logic [13:0] A_VERSION     = 14'd3;
    localparam logic [13:0] A_OPS         = 14'd6;
    localparam logic [13:0] A_OP_ID       = 14'd1;

    typedef enum logic [2:0] {
        PH_HEADER, PH_OUTER, PH_BUCKETS, PH_INNER, PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        CAP_NONE, CAP_ID, CAP_NAME, CAP_VER, CAP_OP
    } t_cap;

    typedef enum logic [1:0] {
        K_SUMMARY, K_NAME, K_OPS
    } t_kind;

    typedef enum logic [2:0] {
        ST_ACCEPTED, ST_WRONG_TYPE, ST_TOO_SHORT, ST_CATALOG_FULL, ST_MISSING, ST_TRUNCATED
    } t_status;

    typedef enum logic [2:0] {
        BK_IDLE, BK_SUM, BK_NAME, BK_OP_RD, BK_OP_OUT
    } t_back_state;

    // Per-message summary handed from the parser to the emitter.
    typedef struct packed {
        t_status     status;
        logic [15:0] family_id;
        logic [7:0]  version;
        logic [7:0]  op_count;
        logic [6:0]  slot;
        logic        bank;
    } t_sum;

endpackage

// ----- hw/rtl/gfr_if.sv -----
// ----------------------------------------------------------------------------
// gfr_if
// Stream channels of the family record parser: byte input and result output.
// ----------------------------------------------------------------------------
interface gfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface gfr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [15:0] family_id;
    logic [7:0]  version;
    logic [7:0]  op_count;
    logic [6:0]  family_slot;
    logic [63:0] data_word;
    logic        last;

    modport source (output valid, output kind, output status, output family_id,
                    output version, output op_count, output family_slot,
                    output data_word, output last, input ready);
    modport sink   (input valid, input kind, input status, input family_id,
                    input version, input op_count, input family_slot,
                    input data_word, input last, output ready);
endinterface

// ----- hw/rtl/gfr_ram.sv -----
// ----------------------------------------------------------------------------
// gfr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module gfr_ram #(
    parameter int W     = 64,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/gfr_front.sv -----
// ----------------------------------------------------------------------------
// gfr_front
// Byte parser: collects the headers, walks the attributes and captures fields.
// ----------------------------------------------------------------------------
module gfr_front import gfr_pkg::*; #(
    parameter int MAX_OPS     = MAX_OPS_DEF,
    parameter int MAX_CATALOG = MAX_CATALOG_DEF,
    parameter int NAME_BYTES  = NAME_BYTES_DEF,
    parameter int NL_W        = $clog2(NAME_BYTES),
    parameter int AW          = $clog2(2 * ((MAX_OPS + 7) / 8))
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [15:0]             i_ctrl_type,
    input  logic                    i_valid,
    input  logic [7:0]              i_byte,
    input  logic                    i_last,
    input  logic                    i_space,
    output logic                    o_ready,
    output logic                    o_push,
    output t_sum                    o_sum,
    output logic [NAME_BYTES*8-1:0] o_name,
    output logic [NL_W-1:0]         o_name_len,
    output logic                    o_we,
    output logic [AW-1:0]           o_waddr,
    output logic [63:0]             o_wdata
);

    localparam int OPW  = (MAX_OPS + 7) / 8;
    localparam int NI_W = $clog2(NAME_BYTES);
    localparam int FC_W = $clog2(MAX_CATALOG + 1);

    logic [15:0]       r_pos, n_pos;
    logic [31:0]       r_decl, n_decl;
    logic [15:0]       r_type, n_type;
    t_phase            r_phase, n_phase;
    logic [OFS_W-1:0]  r_attr_next, n_attr_next;
    logic [OFS_W-1:0]  r_cont_end, n_cont_end;
    logic [OFS_W-1:0]  r_bucket_next, n_bucket_next;
    logic [OFS_W-1:0]  r_bucket_end, n_bucket_end;
    logic [OFS_W-1:0]  r_inner_next, n_inner_next;
    logic [1:0]        r_hdr_cnt, n_hdr_cnt;
    logic [15:0]       r_hdr_start, n_hdr_start;
    logic [23:0]       r_field, n_field;
    t_cap              r_cap, n_cap;
    logic [OFS_W-1:0]  r_cap_start, n_cap_start;
    logic [15:0]       r_id, n_id;
    logic [7:0]        r_ver, n_ver;
    logic [7:0]        r_name [NAME_BYTES];
    logic [7:0]        n_name [NAME_BYTES];
    logic [NL_W-1:0]   r_name_len, n_name_len;
    logic [7:0]        r_op_total, n_op_total;
    logic [63:0]       r_op_word, n_op_word;
    logic              r_bank, n_bank;
    logic [FC_W-1:0]   r_fam_cnt, n_fam_cnt;

    logic accept;

    assign o_ready = i_space;
    assign accept  = i_valid && i_space;

    function automatic logic [OFS_W-1:0] level_next(input t_phase ph);
        case (ph)
            PH_OUTER:   level_next = r_attr_next;
            PH_BUCKETS: level_next = r_bucket_next;
            default:    level_next = r_inner_next;
        endcase
    endfunction

    function automatic logic [31:0] level_limit(input t_phase ph);
        case (ph)
            PH_OUTER:   level_limit = r_decl;
            PH_BUCKETS: level_limit = 32'(r_cont_end);
            default:    level_limit = 32'(r_bucket_end);
        endcase
    endfunction

    function automatic t_phase level_pop(input t_phase ph);
        case (ph)
            PH_OUTER:   level_pop = PH_DONE;
            PH_BUCKETS: level_pop = PH_OUTER;
            PH_INNER:   level_pop = PH_BUCKETS;
            default:    level_pop = ph;
        endcase
    endfunction

    always_comb begin
        t_phase           ph;
        logic             started;
        logic             done;
        logic [15:0]      len;
        logic [13:0]      typ;
        logic [31:0]      room;
        logic [OFS_W-1:0] nxt;
        logic [15:0]      pay;
        logic [OFS_W-1:0] k;
        logic [63:0]      word;
        t_status          st;
        logic             name_empty;

        n_pos = r_pos; n_decl = r_decl; n_type = r_type; n_phase = r_phase;
        n_attr_next = r_attr_next; n_cont_end = r_cont_end;
        n_bucket_next = r_bucket_next; n_bucket_end = r_bucket_end;
        n_inner_next = r_inner_next; n_hdr_cnt = r_hdr_cnt;
        n_hdr_start = r_hdr_start; n_field = r_field; n_cap = r_cap;
        n_cap_start = r_cap_start; n_id = r_id; n_ver = r_ver;
        n_name = r_name; n_name_len = r_name_len; n_op_total = r_op_total;
        n_op_word = r_op_word; n_bank = r_bank; n_fam_cnt = r_fam_cnt;
        o_we = 1'b0; o_waddr = '0; o_wdata = r_op_word;
        o_push = 1'b0; o_sum = '0; o_name = '0; o_name_len = '0;
        ph = r_phase; started = 1'b0; done = 1'b0;
        len = r_field[15:0]; typ = {i_byte[5:0], r_field[23:16]};
        room = '0; nxt = '0; pay = '0; word = '0; st = ST_ACCEPTED;
        name_empty = 1'b0;
        k = OFS_W'(r_pos) - r_cap_start;

        if (accept && r_pos != POS_MAX) begin
            if (r_pos < HDR_BYTES) begin
                if (r_pos < 16'd4) begin
                    n_decl = r_decl | (32'(i_byte) << {r_pos[1:0], 3'b000});
                end else if (r_pos == 16'd4) begin
                    n_type[7:0] = r_type[7:0] | i_byte;
                end else if (r_pos == 16'd5) begin
                    n_type[15:8] = r_type[15:8] | i_byte;
                end else if (r_pos == 16'd17) begin
                    n_ver = i_byte;
                end
                if (r_pos == HDR_BYTES - 16'd1) begin
                    n_phase = PH_OUTER;
                    n_attr_next = OFS_W'(HDR_BYTES);
                end
            end else if (r_hdr_cnt != 2'd0) begin
                if (r_hdr_cnt == 2'd3) begin
                    // Fourth header byte: decode length and type.
                    n_hdr_cnt = 2'd0;
                    room = level_limit(r_phase) - 32'(r_hdr_start);
                    if (len < 16'd4 || 32'(len) > room) begin
                        n_phase = level_pop(r_phase);
                    end else begin
                        nxt = OFS_W'(r_hdr_start) + ((OFS_W'(len) + OFS_W'(3)) & ~OFS_W'(3));
                        pay = len - 16'd4;
                        n_cap_start = OFS_W'(r_hdr_start) + OFS_W'(4);
                        case (r_phase)
                            PH_OUTER: begin
                                n_attr_next = nxt;
                                if (typ == A_FAMILY_ID) begin
                                    if (pay >= 16'd2) n_cap = CAP_ID;
                                end else if (typ == A_FAMILY_NAME) begin
                                    n_name_len = (pay < 16'(NAME_BYTES - 1)) ?
                                        NL_W'(pay) : NL_W'(NAME_BYTES - 1);
                                    n_cap = CAP_NAME;
                                end else if (typ == A_VERSION) begin
                                    if (pay >= 16'd4) n_cap = CAP_VER;
                                end else if (typ == A_OPS) begin
                                    n_cont_end = OFS_W'(r_hdr_start) + OFS_W'(len);
                                    n_bucket_next = OFS_W'(r_hdr_start) + OFS_W'(4);
                                    n_phase = PH_BUCKETS;
                                end
                            end
                            PH_BUCKETS: begin
                                n_bucket_next = nxt;
                                n_bucket_end = OFS_W'(r_hdr_start) + OFS_W'(len);
                                n_inner_next = OFS_W'(r_hdr_start) + OFS_W'(4);
                                n_phase = PH_INNER;
                            end
                            default: begin
                                n_inner_next = nxt;
                                if (typ == A_OP_ID && len >= 16'd8) n_cap = CAP_OP;
                            end
                        endcase
                    end
                end else begin
                    n_field = r_field | (24'(i_byte) << {r_hdr_cnt, 3'b000});
                    n_hdr_cnt = r_hdr_cnt + 2'd1;
                end
            end else begin
                // A failed guard drops one nesting level and the next level is tried.
                for (int it = 0; it < 3; it++) begin
                    if (!done && (ph == PH_OUTER || ph == PH_BUCKETS || ph == PH_INNER)
                        && OFS_W'(r_pos) == level_next(ph)) begin
                        if ((33'(r_pos) + 33'd4 <= 33'(level_limit(ph))) &&
                            !(ph == PH_BUCKETS && 32'(r_op_total) >= 32'(MAX_OPS))) begin
                            started = 1'b1;
                            done = 1'b1;
                        end else begin
                            ph = level_pop(ph);
                        end
                    end else begin
                        done = 1'b1;
                    end
                end
                n_phase = ph;
                if (started) begin
                    n_hdr_cnt = 2'd1;
                    n_hdr_start = r_pos;
                    n_field = 24'(i_byte);
                    n_cap = CAP_NONE;
                end else begin
                    case (r_cap)
                        CAP_ID: begin
                            if (k == '0) begin
                                n_id[7:0] = i_byte;
                            end else if (k == OFS_W'(1)) begin
                                n_id[15:8] = i_byte;
                                n_cap = CAP_NONE;
                            end
                        end
                        CAP_NAME: begin
                            if (k < OFS_W'(r_name_len) && k < OFS_W'(NAME_BYTES)) begin
                                n_name[k[NI_W-1:0]] = i_byte;
                            end else begin
                                n_cap = CAP_NONE;
                            end
                        end
                        CAP_VER: begin
                            if (k == '0) n_ver = i_byte;
                            n_cap = CAP_NONE;
                        end
                        CAP_OP: begin
                            if (k == '0 && 32'(r_op_total) < 32'(MAX_OPS)) begin
                                word = (r_op_total[2:0] == 3'd0) ? 64'd0 : r_op_word;
                                word[{r_op_total[2:0], 3'b000} +: 8] = i_byte & LOW_BYTE;
                                n_op_word = word;
                                o_we = 1'b1;
                                o_wdata = word;
                                o_waddr = r_bank ? AW'(OPW) + AW'(r_op_total[7:3]) :
                                                   AW'(r_op_total[7:3]);
                                n_op_total = r_op_total + 8'd1;
                            end
                            n_cap = CAP_NONE;
                        end
                        default: ;
                    endcase
                end
            end
            n_pos = r_pos + 16'd1;
        end

        if (accept && i_last) begin
            name_empty = (n_name_len == '0) || (n_name[0] == 8'd0);
            if (n_pos < 16'd6)                          st = ST_TRUNCATED;
            else if (n_type != i_ctrl_type)             st = ST_WRONG_TYPE;
            else if (32'(r_fam_cnt) >= 32'(MAX_CATALOG)) st = ST_CATALOG_FULL;
            else if (n_decl < 32'(HDR_BYTES))           st = ST_TOO_SHORT;
            else if (32'(n_pos) < n_decl)               st = ST_TRUNCATED;
            else if (n_id == 16'd0 || name_empty)       st = ST_MISSING;
            else                                        st = ST_ACCEPTED;
            o_push = 1'b1;
            o_sum.status    = st;
            o_sum.family_id = n_id;
            o_sum.version   = n_ver;
            o_sum.op_count  = n_op_total;
            o_sum.slot      = (st == ST_ACCEPTED) ? SLOT_W'(r_fam_cnt) : '0;
            o_sum.bank      = r_bank;
            for (int i = 0; i < NAME_BYTES; i++) begin
                o_name[i*8 +: 8] = n_name[i];
            end
            o_name_len = n_name_len;
            if (st == ST_ACCEPTED) n_fam_cnt = r_fam_cnt + FC_W'(1);
            n_bank = !r_bank;
            n_pos = '0; n_decl = '0; n_type = '0; n_phase = PH_HEADER;
            n_attr_next = '0; n_cont_end = '0; n_bucket_next = '0;
            n_bucket_end = '0; n_inner_next = '0; n_hdr_cnt = '0;
            n_hdr_start = '0; n_field = '0; n_cap = CAP_NONE; n_cap_start = '0;
            n_id = '0; n_ver = '0; n_name_len = '0; n_op_total = '0;
            n_op_word = '0;
            for (int i = 0; i < NAME_BYTES; i++) begin
                n_name[i] = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_decl <= '0; r_type <= '0; r_phase <= PH_HEADER;
            r_attr_next <= '0; r_cont_end <= '0; r_bucket_next <= '0;
            r_bucket_end <= '0; r_inner_next <= '0; r_hdr_cnt <= '0;
            r_hdr_start <= '0; r_field <= '0; r_cap <= CAP_NONE;
            r_cap_start <= '0; r_id <= '0; r_ver <= '0; r_name_len <= '0;
            r_op_total <= '0; r_op_word <= '0; r_bank <= 1'b0; r_fam_cnt <= '0;
            for (int i = 0; i < NAME_BYTES; i++) begin
                r_name[i] <= 8'd0;
            end
        end else begin
            r_pos <= n_pos; r_decl <= n_decl; r_type <= n_type; r_phase <= n_phase;
            r_attr_next <= n_attr_next; r_cont_end <= n_cont_end;
            r_bucket_next <= n_bucket_next; r_bucket_end <= n_bucket_end;
            r_inner_next <= n_inner_next; r_hdr_cnt <= n_hdr_cnt;
            r_hdr_start <= n_hdr_start; r_field <= n_field; r_cap <= n_cap;
            r_cap_start <= n_cap_start; r_id <= n_id; r_ver <= n_ver;
            r_name_len <= n_name_len; r_op_total <= n_op_total;
            r_op_word <= n_op_word; r_bank <= n_bank; r_fam_cnt <= n_fam_cnt;
            r_name <= n_name;
        end
    end

endmodule

// ----- hw/rtl/gfr_queue.sv -----
// ----------------------------------------------------------------------------
// gfr_queue
// Two-entry queue of finished message summaries between parser and emitter.
// ----------------------------------------------------------------------------
module gfr_queue import gfr_pkg::*; #(
    parameter int NAME_BYTES = NAME_BYTES_DEF,
    parameter int NL_W       = $clog2(NAME_BYTES)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  t_sum                    i_sum,
    input  logic [NAME_BYTES*8-1:0] i_name,
    input  logic [NL_W-1:0]         i_name_len,
    input  logic                    i_pop,
    output logic                    o_space,
    output logic                    o_avail,
    output t_sum                    o_sum,
    output logic [NAME_BYTES*8-1:0] o_name,
    output logic [NL_W-1:0]         o_name_len
);

    t_sum                    r_sum [2];
    logic [NAME_BYTES*8-1:0] r_name [2];
    logic [NL_W-1:0]         r_nlen [2];
    logic                    r_wp, r_rp;
    logic [1:0]              r_cnt;

    assign o_space    = (r_cnt != 2'd2);
    assign o_avail    = (r_cnt != 2'd0);
    assign o_sum      = r_sum[r_rp];
    assign o_name     = r_name[r_rp];
    assign o_name_len = r_nlen[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_sum[r_wp]  <= i_sum;
            r_name[r_wp] <= i_name;
            r_nlen[r_wp] <= i_name_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != 2'd2 || i_pop))
        else $error("summary pushed into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != 2'd0)
        else $error("summary popped from an empty queue");
`endif

endmodule

// ----- hw/rtl/gfr_back.sv -----
// ----------------------------------------------------------------------------
// gfr_back
// Result emitter: summary, name words and packed operation words per message.
// ----------------------------------------------------------------------------
module gfr_back import gfr_pkg::*; #(
    parameter int MAX_OPS    = MAX_OPS_DEF,
    parameter int NAME_BYTES = NAME_BYTES_DEF,
    parameter int NL_W       = $clog2(NAME_BYTES),
    parameter int AW         = $clog2(2 * ((MAX_OPS + 7) / 8))
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_avail,
    input  t_sum                    i_sum,
    input  logic [NAME_BYTES*8-1:0] i_name,
    input  logic [NL_W-1:0]         i_name_len,
    output logic                    o_pop,
    output logic [AW-1:0]           o_raddr,
    input  logic [63:0]             i_rdata,
    gfr_out_if.source               o_out
);

    localparam int OPW  = (MAX_OPS + 7) / 8;
    localparam int NW   = (NAME_BYTES + 7) / 8;
    localparam int WMAX = (NW > OPW) ? NW : OPW;
    localparam int WI_W = $clog2(WMAX + 1);

    t_back_state     r_state, n_state;
    logic [WI_W-1:0] r_wi, n_wi;
    logic            r_ov;
    t_kind           r_kind;
    t_status         r_status;
    logic [15:0]     r_id;
    logic [7:0]      r_ver, r_opc;
    logic [6:0]      r_slot;
    logic [63:0]     r_word;
    logic            r_last;

    logic            free, load, ld_last;
    t_kind           ld_kind;
    logic [63:0]     ld_word;
    logic [5:0]      op_words;
    logic [NW*64-1:0] name_pad;
    logic [63:0]     name_word;

    assign free     = !r_ov || o_out.ready;
    assign op_words = 6'((9'(i_sum.op_count) + 9'd7) >> 3);
    assign name_pad = (NW*64)'(i_name);
    assign o_raddr  = i_sum.bank ? AW'(OPW) + AW'(r_wi) : AW'(r_wi);

    always_comb begin
        logic [WI_W+3:0] idx;
        name_word = name_pad[r_wi*64 +: 64];
        for (int j = 0; j < 8; j++) begin
            idx = {r_wi, 3'b000} + (WI_W+4)'(j);
            if (idx >= (WI_W+4)'(i_name_len)) name_word[j*8 +: 8] = 8'd0;
        end
    end

    always_comb begin
        n_state = r_state;
        n_wi    = r_wi;
        load    = 1'b0;
        ld_kind = K_SUMMARY;
        ld_word = 64'd0;
        ld_last = 1'b0;
        o_pop   = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_avail) n_state = BK_SUM;
            end
            BK_SUM: begin
                if (free) begin
                    load    = 1'b1;
                    ld_last = (i_sum.status != ST_ACCEPTED);
                    n_wi    = '0;
                    if (i_sum.status != ST_ACCEPTED) begin
                        o_pop   = 1'b1;
                        n_state = BK_IDLE;
                    end else begin
                        n_state = BK_NAME;
                    end
                end
            end
            BK_NAME: begin
                if (free) begin
                    load    = 1'b1;
                    ld_kind = K_NAME;
                    ld_word = name_word;
                    ld_last = (op_words == 6'd0) && (r_wi == WI_W'(NW - 1));
                    if (r_wi == WI_W'(NW - 1)) begin
                        n_wi = '0;
                        if (op_words == 6'd0) begin
                            o_pop   = 1'b1;
                            n_state = BK_IDLE;
                        end else begin
                            n_state = BK_OP_RD;
                        end
                    end else begin
                        n_wi = r_wi + WI_W'(1);
                    end
                end
            end
            BK_OP_RD: begin
                // The read address has been presented; data arrives next cycle.
                n_state = BK_OP_OUT;
            end
            BK_OP_OUT: begin
                if (free) begin
                    load    = 1'b1;
                    ld_kind = K_OPS;
                    ld_word = i_rdata;
                    ld_last = (6'(r_wi) + 6'd1 == op_words);
                    if (ld_last) begin
                        o_pop   = 1'b1;
                        n_state = BK_IDLE;
                    end else begin
                        n_wi    = r_wi + WI_W'(1);
                        n_state = BK_OP_RD;
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_wi    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wi    <= n_wi;
            if (load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind   <= ld_kind;
            r_status <= i_sum.status;
            r_id     <= i_sum.family_id;
            r_ver    <= i_sum.version;
            r_opc    <= i_sum.op_count;
            r_slot   <= i_sum.slot;
            r_word   <= ld_word;
            r_last   <= ld_last;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.kind        = r_kind;
    assign o_out.status      = r_status;
    assign o_out.family_id   = r_id;
    assign o_out.version     = r_ver;
    assign o_out.op_count    = r_opc;
    assign o_out.family_slot = r_slot;
    assign o_out.data_word   = r_word;
    assign o_out.last        = r_last;

`ifndef SYNTHESIS
    a_busy_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != BK_IDLE |-> i_avail)
        else $error("emitter busy without a queued summary");
    a_words_only_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_kind != K_SUMMARY) |-> r_status == ST_ACCEPTED)
        else $error("data word emitted for a rejected message");
    a_reject_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_kind == K_SUMMARY && r_status != ST_ACCEPTED) |-> r_last)
        else $error("rejected summary not marked last");
`endif

endmodule

// ----- hw/rtl/genl_family_record_parser.sv -----
// ----------------------------------------------------------------------------
// genl_family_record_parser
// Parses a family-description message byte by byte and emits its records.
// ----------------------------------------------------------------------------
// Channel   Dir  Carries                                         Handshake
// i_in      in   data_byte, last_byte                            valid/ready
// o_out     out  kind, status, family_id, version, op_count,
//                family_slot, data_word, last                    valid/ready
// i_cfg_*   in   controller type (16 bits)                       write enable
//
// One byte is taken per cycle while fewer than two finished messages wait in
// the summary queue; the parser itself keeps no bubble between bytes.
// An accepted message gives 1 summary, (NAME_BYTES+7)/8 name words and one
// word per eight operation ids; each op word has a RAM read state before output.
// Reset is synchronous and active low; it clears the walk state, the family
// count, the queue and the output register. Output stalls back up into the
// queue, and the input stalls only once the queue is full.
module genl_family_record_parser import gfr_pkg::*; #(
    parameter int MAX_OPS     = MAX_OPS_DEF,
    parameter int MAX_CATALOG = MAX_CATALOG_DEF,
    parameter int NAME_BYTES  = NAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    gfr_in_if.sink      i_in,
    gfr_out_if.source   o_out
);

    localparam int OPW  = (MAX_OPS + 7) / 8;
    localparam int AW   = $clog2(2 * OPW);
    localparam int NL_W = $clog2(NAME_BYTES);

    logic [15:0]             r_ctrl_type;
    logic                    space, push, pop, avail, we;
    t_sum                    f_sum, q_sum;
    logic [NAME_BYTES*8-1:0] f_name, q_name;
    logic [NL_W-1:0]         f_nlen, q_nlen;
    logic [AW-1:0]           waddr, raddr;
    logic [63:0]             wdata, rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_type <= CTRL_TYPE_RST;
        end else if (i_cfg_we) begin
            r_ctrl_type <= i_cfg_data;
        end
    end

    gfr_front #(
        .MAX_OPS(MAX_OPS), .MAX_CATALOG(MAX_CATALOG), .NAME_BYTES(NAME_BYTES),
        .NL_W(NL_W), .AW(AW)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl_type(r_ctrl_type),
        .i_valid(i_in.valid), .i_byte(i_in.data_byte), .i_last(i_in.last_byte),
        .i_space(space), .o_ready(i_in.ready), .o_push(push), .o_sum(f_sum),
        .o_name(f_name), .o_name_len(f_nlen), .o_we(we), .o_waddr(waddr),
        .o_wdata(wdata)
    );

    gfr_queue #(.NAME_BYTES(NAME_BYTES), .NL_W(NL_W)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_sum(f_sum),
        .i_name(f_name), .i_name_len(f_nlen), .i_pop(pop), .o_space(space),
        .o_avail(avail), .o_sum(q_sum), .o_name(q_name), .o_name_len(q_nlen)
    );

    gfr_ram #(.W(64), .DEPTH(2 * OPW), .AW(AW)) u_op_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    gfr_back #(
        .MAX_OPS(MAX_OPS), .NAME_BYTES(NAME_BYTES), .NL_W(NL_W), .AW(AW)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_avail(avail), .i_sum(q_sum),
        .i_name(q_name), .i_name_len(q_nlen), .o_pop(pop), .o_raddr(raddr),
        .i_rdata(rdata), .o_out(o_out)
    );

endmodule
